// File: sv/rhc_pkg.sv
// shared types, field widths and codes of the rgb histogram classifier
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int BIN_COUNT_DEF  = 256;
  localparam int COUNT_BITS_DEF = 24;

  localparam int CH_W     = 8;
  localparam int DIM_W    = 12;
  localparam int TOTAL_W  = 24;
  localparam int SHARE_W  = 7;
  localparam int SUM_W    = 10;
  localparam int CFG_IDX_W = 2;

  localparam int IN_FIELDS_W  = 2 + 4 * CH_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 * TOTAL_W + 3 * SHARE_W + 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [SHARE_W-1:0] PCT       = SHARE_W'(100);

  localparam int MONO_LOW  = 1;
  localparam int MONO_MID  = 253;
  localparam int MONO_HIGH = 255;

  typedef enum logic [1:0] {
    MODE_ACCUM = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // true when floor(sum / 3) is one of the monochrome levels
  function automatic logic mono_sum(input logic [SUM_W-1:0] s);
    return (s >= SUM_W'(3 * MONO_LOW)  && s <= SUM_W'(3 * MONO_LOW + 2))  ||
           (s >= SUM_W'(3 * MONO_MID)  && s <= SUM_W'(3 * MONO_MID + 2))  ||
           (s >= SUM_W'(3 * MONO_HIGH) && s <= SUM_W'(3 * MONO_HIGH + 2));
  endfunction

endpackage

// File: sv/rgb_histogram_classifier.sv
// top level: three channel histograms in memories, image-kind flags, bin read with shares
`timescale 1ns / 1ps

// Pixels (mode 0) are taken one per cycle: each channel memory is read when the item is
// accepted and written back incremented in the next cycle, with the write forwarded into a
// read of the same bin. A read item (mode 1) holds in_tready low while the three counts are
// latched and then, per channel, count * 100 is formed and divided by width * height in a
// shared restoring divider; the result then sits in the output register while pixels flow
// on. A clear item (mode 2), and reset, run a clearing pass through all BIN_COUNT bins of
// the memories, during which no item is accepted; configuration writes are taken at any
// time. Mode 3 is accepted and ignored.
module rgb_histogram_classifier #(
  parameter int BIN_COUNT  = rhc_pkg::BIN_COUNT_DEF,
  parameter int COUNT_BITS = rhc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // mode, red, green, blue, bin_index
  input  logic [rhc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // red_total, green_total, blue_total, red_share, green_share, blue_share, all_gray, all_mono
  output logic [rhc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [rhc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rhc_pkg::DIM_W-1:0]        cfg_data
);

  localparam int ADDR_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int AREA_W = 2 * rhc_pkg::DIM_W;
  localparam int NUM_W  = COUNT_BITS + rhc_pkg::SHARE_W;
  localparam int DIV_W  = (NUM_W > AREA_W + rhc_pkg::SHARE_W) ? NUM_W
                                                              : AREA_W + rhc_pkg::SHARE_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_CLR,
    S_RUN,
    S_CAP,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  state_t state_r;

  logic [rhc_pkg::DIM_W-1:0] width_r;
  logic [rhc_pkg::DIM_W-1:0] height_r;

  logic [1:0]               in_mode;
  logic [rhc_pkg::CH_W-1:0] chan [3];
  logic [rhc_pkg::CH_W-1:0] in_bin;
  logic [rhc_pkg::SUM_W-1:0] in_sum;
  logic                     accept;

  logic [COUNT_BITS-1:0] mem_r [3][BIN_COUNT];
  logic [COUNT_BITS-1:0] rd_q_r [3];
  logic [ADDR_W-1:0]     ra [3];
  logic                  we [3];
  logic [ADDR_W-1:0]     wa [3];
  logic [COUNT_BITS-1:0] wd [3];

  logic [ADDR_W-1:0] clr_addr_r;
  logic              p_v_r;
  logic              p_ok_r [3];
  logic [ADDR_W-1:0] p_addr_r [3];
  logic              gray_r;
  logic              mono_r;
  logic              rd_ok_r;

  logic [COUNT_BITS-1:0]       cnt_r [3];
  logic [AREA_W-1:0]           area_r;
  logic [NUM_W-1:0]            num_r;
  logic [2:0]                  bit_r;
  logic [rhc_pkg::SHARE_W-1:0] quo_r;
  logic [1:0]                  ch_r;
  logic [rhc_pkg::SHARE_W-1:0] share_r [3];

  logic [rhc_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                           out_tvalid_r;

  logic [DIV_W-1:0]            div_num;
  logic [DIV_W-1:0]            div_sub;
  logic                        div_take;
  logic [rhc_pkg::SHARE_W-1:0] quo_nxt;
  logic [rhc_pkg::SHARE_W-1:0] share_nxt;

  function automatic logic in_range(input logic [rhc_pkg::CH_W-1:0] v);
    return 32'(v) < 32'(BIN_COUNT);
  endfunction

  function automatic logic [rhc_pkg::TOTAL_W-1:0] total_of(input logic [COUNT_BITS-1:0] c);
    return (32'(c) > 32'(rhc_pkg::TOTAL_MAX)) ? rhc_pkg::TOTAL_MAX : rhc_pkg::TOTAL_W'(c);
  endfunction

  assign in_mode  = in_tdata[1:0];
  assign chan[0]  = in_tdata[2 +: rhc_pkg::CH_W];
  assign chan[1]  = in_tdata[2 + rhc_pkg::CH_W +: rhc_pkg::CH_W];
  assign chan[2]  = in_tdata[2 + 2 * rhc_pkg::CH_W +: rhc_pkg::CH_W];
  assign in_bin   = in_tdata[2 + 3 * rhc_pkg::CH_W +: rhc_pkg::CH_W];
  assign in_sum   = rhc_pkg::SUM_W'(chan[0]) + rhc_pkg::SUM_W'(chan[1])
                  + rhc_pkg::SUM_W'(chan[2]);

  assign in_tready  = (state_r == S_RUN);
  assign accept     = in_tvalid && in_tready;
  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rhc_pkg::DIM_W'(1);
      height_r <= rhc_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        rhc_pkg::REG_WIDTH:  width_r  <= cfg_data;
        rhc_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // memory ports
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ra[c] = (in_mode == rhc_pkg::MODE_READ) ? ADDR_W'(in_bin) : ADDR_W'(chan[c]);
      if (state_r == S_CLR) begin
        we[c] = 1'b1;
        wa[c] = clr_addr_r;
        wd[c] = '0;
      end else begin
        we[c] = p_v_r && p_ok_r[c] && (rd_q_r[c] != CNT_MAX);
        wa[c] = p_addr_r[c];
        wd[c] = rd_q_r[c] + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (we[c]) begin
        mem_r[c][wa[c]] <= wd[c];
      end
      // forward a write-back into a read of the same bin
      rd_q_r[c] <= (we[c] && (wa[c] == ra[c])) ? wd[c] : mem_r[c][ra[c]];
    end
  end

  // shared divider step
  always_comb begin
    div_num   = DIV_W'(num_r);
    div_sub   = DIV_W'(area_r) << bit_r;
    div_take  = (div_num >= div_sub);
    quo_nxt   = quo_r | (div_take ? (rhc_pkg::SHARE_W'(1) << bit_r) : '0);
    if (area_r == '0) begin
      share_nxt = '0;
    end else if (32'(cnt_r[ch_r]) >= 32'(area_r)) begin
      share_nxt = rhc_pkg::PCT;
    end else begin
      share_nxt = quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_addr_r   <= '0;
      p_v_r        <= 1'b0;
      gray_r       <= 1'b1;
      mono_r       <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      p_v_r <= accept && (in_mode == rhc_pkg::MODE_ACCUM);
      if (accept) begin
        for (int c = 0; c < 3; c++) begin
          p_ok_r[c]   <= in_range(chan[c]);
          p_addr_r[c] <= ADDR_W'(chan[c]);
        end
        rd_ok_r <= in_range(in_bin);
      end
      case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(BIN_COUNT - 1)) begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (accept) begin
            case (in_mode)
              rhc_pkg::MODE_ACCUM: begin
                gray_r <= gray_r && (chan[0] == chan[1]) && (chan[1] == chan[2]);
                mono_r <= mono_r && rhc_pkg::mono_sum(in_sum);
              end
              rhc_pkg::MODE_READ: begin
                state_r <= S_CAP;
              end
              rhc_pkg::MODE_CLEAR: begin
                gray_r     <= 1'b1;
                mono_r     <= 1'b1;
                clr_addr_r <= '0;
                state_r    <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_CAP: begin
          for (int c = 0; c < 3; c++) begin
            cnt_r[c] <= rd_ok_r ? rd_q_r[c] : '0;
          end
          area_r  <= AREA_W'(width_r) * AREA_W'(height_r);
          ch_r    <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          num_r   <= NUM_W'(cnt_r[ch_r]) * NUM_W'(rhc_pkg::PCT);
          bit_r   <= 3'(rhc_pkg::SHARE_W - 1);
          quo_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_take) begin
            num_r <= NUM_W'(div_num - div_sub);
          end
          quo_r <= quo_nxt;
          bit_r <= bit_r - 3'(1);
          if (bit_r == '0) begin
            share_r[ch_r] <= share_nxt;
            if (ch_r == 2'(2)) begin
              state_r <= S_OUT;
            end else begin
              ch_r    <= ch_r + 2'(1);
              state_r <= S_MUL;
            end
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r <= {(rhc_pkg::OUT_DATA_W - rhc_pkg::OUT_FIELDS_W)'(0),
                            mono_r, gray_r,
                            share_r[2], share_r[1], share_r[0],
                            total_of(cnt_r[2]), total_of(cnt_r[1]), total_of(cnt_r[0])};
            out_tvalid_r <= 1'b1;
            state_r      <= S_RUN;
          end
        end
        default: state_r <= S_CLR;
      endcase
    end
  end

endmodule

// File: sv/rhc_checker.sv
// port-level assertions for the rgb histogram classifier, bound to the top level
`timescale 1ns / 1ps

module rhc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic [rhc_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [rhc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready
);

  localparam int SH0 = 3 * rhc_pkg::TOTAL_W;
  localparam int SH1 = SH0 + rhc_pkg::SHARE_W;
  localparam int SH2 = SH1 + rhc_pkg::SHARE_W;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // read and clear items take the input ready low right after they are accepted
  a_read_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tdata[1:0] == rhc_pkg::MODE_READ || in_tdata[1:0] == rhc_pkg::MODE_CLEAR)
    |=> !in_tready)
    else $error("input ready right after a read or clear item");

  // shares never exceed one hundred
  a_share_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SH0 +: rhc_pkg::SHARE_W] <= rhc_pkg::PCT &&
                   out_tdata[SH1 +: rhc_pkg::SHARE_W] <= rhc_pkg::PCT &&
                   out_tdata[SH2 +: rhc_pkg::SHARE_W] <= rhc_pkg::PCT)
    else $error("share above one hundred");

  // empty red bin gives zero red share
  a_zero_share: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[rhc_pkg::TOTAL_W-1:0] == '0
    |-> out_tdata[SH0 +: rhc_pkg::SHARE_W] == '0)
    else $error("nonzero share for empty red bin");

  // clearing pass runs after reset
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready)
    else $error("input ready before clearing pass");

endmodule

bind rgb_histogram_classifier rhc_checker u_rhc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tdata   (in_tdata),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// File: tb/tb_rgb_histogram_classifier.sv
// testbench for rgb_histogram_classifier: pixel stream stimulus, self-checking bin reads
`timescale 1ns / 1ps

module tb_rgb_histogram_classifier;
  import rhc_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned COUNT_CAP = (1 << COUNT_BITS_DEF) - 1;
  localparam int SETTLE_CYCLES = BIN_COUNT_DEF + 60;

  typedef struct {
    logic [1:0]      mode;
    logic [CH_W-1:0] red, green, blue, bin;
  } pix_item_t;

  // lowest bits first: red_total, green_total, blue_total, shares, all_gray, all_mono
  typedef struct packed {
    logic               mono;
    logic               gray;
    logic [SHARE_W-1:0] blue_share, green_share, red_share;
    logic [TOTAL_W-1:0] blue_total, green_total, red_total;
  } bin_report_t;

  logic                    clk;
  logic                    rst_n;
  // mode, red, green, blue, bin_index
  logic [IN_DATA_W-1:0]    in_tdata;
  logic                    in_tvalid;
  logic                    in_tready;
  // red_total, green_total, blue_total, red_share, green_share, blue_share, all_gray, all_mono
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [DIM_W-1:0]        cfg_data;

  rgb_histogram_classifier uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  int unsigned red_hist [BIN_COUNT_DEF];
  int unsigned green_hist [BIN_COUNT_DEF];
  int unsigned blue_hist [BIN_COUNT_DEF];
  bit          gray_ok, mono_ok;
  int unsigned img_w, img_h;

  pix_item_t   pending[$];
  bin_report_t reports_due[$];
  pix_item_t   cur_item;
  int          in_flight;
  int          burst_left, gap_left, rx_tick;
  bit          steady;
  int          errors;
  int          stim_count;
  logic [CH_W-1:0] seen[$];
  logic [CH_W-1:0] pal [4][3];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void clear_hist();
    foreach (red_hist[i]) begin
      red_hist[i] = 0;
      green_hist[i] = 0;
      blue_hist[i] = 0;
    end
    gray_ok = 1'b1;
    mono_ok = 1'b1;
  endfunction

  function automatic logic [SHARE_W-1:0] share_of_count(input int unsigned cnt);
    longint unsigned area, s;
    area = 64'(img_w) * 64'(img_h);
    if (area == 0) return '0;
    s = (64'(cnt) * 64'd100) / area;
    return (s > 100) ? SHARE_W'(100) : SHARE_W'(s);
  endfunction

  function automatic void apply_item(input pix_item_t it);
    int unsigned mean;
    bin_report_t rep;
    in_flight--;
    case (it.mode)
      MODE_ACCUM: begin
        mean = (int'(it.red) + int'(it.green) + int'(it.blue)) / 3;
        if (red_hist[it.red] < COUNT_CAP) red_hist[it.red]++;
        if (green_hist[it.green] < COUNT_CAP) green_hist[it.green]++;
        if (blue_hist[it.blue] < COUNT_CAP) blue_hist[it.blue]++;
        if (it.red != it.green || it.green != it.blue) gray_ok = 1'b0;
        if (mean != 1 && mean != 253 && mean != 255) mono_ok = 1'b0;
      end
      MODE_READ: begin
        rep.red_total   = TOTAL_W'(red_hist[it.bin]);
        rep.green_total = TOTAL_W'(green_hist[it.bin]);
        rep.blue_total  = TOTAL_W'(blue_hist[it.bin]);
        rep.red_share   = share_of_count(red_hist[it.bin]);
        rep.green_share = share_of_count(green_hist[it.bin]);
        rep.blue_share  = share_of_count(blue_hist[it.bin]);
        rep.gray        = gray_ok;
        rep.mono        = mono_ok;
        reports_due = {reports_due, rep};
      end
      MODE_CLEAR: clear_hist();
      default: ;
    endcase
  endfunction

  function automatic void note(input string field, input int unsigned want, got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_tvalid && in_tready) apply_item(cur_item);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur_item = pending.pop_front();
          in_tdata <= IN_DATA_W'({cur_item.bin, cur_item.blue, cur_item.green,
                                  cur_item.red, cur_item.mode});
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            if (steady) gap_left = 0;
            else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(10, 30);
            else gap_left = $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    bin_report_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_tick = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = bin_report_t'(out_tdata[OUT_FIELDS_W-1:0]);
        if (reports_due.size() == 0) begin
          $display("%0t: no report expected, actual %h", $time, got);
          errors++;
        end else begin
          want = reports_due.pop_front();
          note("red_total", want.red_total, got.red_total);
          note("green_total", want.green_total, got.green_total);
          note("blue_total", want.blue_total, got.blue_total);
          note("red_share", want.red_share, got.red_share);
          note("green_share", want.green_share, got.green_share);
          note("blue_share", want.blue_share, got.blue_share);
          note("all_gray", want.gray, got.gray);
          note("all_mono", want.mono, got.mono);
        end
      end
      rx_tick++;
      if (steady) out_tready <= 1'b1;
      else out_tready <= ((rx_tick % 23) >= 4) && ($urandom_range(0, 3) != 0);
    end
  end

  function automatic void queue_item(input logic [1:0] m, input int r, g, b, idx);
    pix_item_t it;
    it.mode = m;
    it.red = CH_W'(r);
    it.green = CH_W'(g);
    it.blue = CH_W'(b);
    it.bin = CH_W'(idx);
    pending = {pending, it};
    in_flight++;
    if (m != MODE_SPARE) stim_count++;
    if (m == MODE_ACCUM) begin
      seen = {seen, (($urandom_range(0, 2) == 0) ? it.red : (it.green ^ it.blue) ^ it.blue)};
      if (seen.size() > 16) void'(seen.pop_front());
    end
  endfunction

  function automatic void add_mono(input bit equal);
    int lvl, s, r, g, rem;
    case ($urandom_range(0, 2))
      0: lvl = 1;
      1: lvl = 253;
      default: lvl = 255;
    endcase
    if (equal) begin
      queue_item(MODE_ACCUM, lvl, lvl, lvl, $urandom_range(0, 255));
    end else begin
      s = 3 * lvl + ((lvl == 255) ? 0 : $urandom_range(0, 2));
      r = $urandom_range((s > 510) ? s - 510 : 0, (s < 255) ? s : 255);
      rem = s - r;
      g = $urandom_range((rem > 255) ? rem - 255 : 0, (rem < 255) ? rem : 255);
      queue_item(MODE_ACCUM, r, g, rem - g, $urandom_range(0, 255));
    end
  endfunction

  function automatic void add_pixel(input int kind);
    int v, k;
    if (kind != 4 && $urandom_range(0, 24) == 0) kind = 4;
    case (kind)
      0: begin
        v = $urandom_range(0, 255);
        queue_item(MODE_ACCUM, v, v, v, $urandom_range(0, 255));
      end
      1: add_mono(1'b0);
      2: add_mono(1'b1);
      3: begin
        k = $urandom_range(0, 3);
        queue_item(MODE_ACCUM, pal[k][0], pal[k][1], pal[k][2], $urandom_range(0, 255));
      end
      default: queue_item(MODE_ACCUM, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DIM_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) img_w = DIM_W'(val);
    else if (idx == REG_HEIGHT) img_h = DIM_W'(val);
  endtask

  task automatic wait_idle();
    while (in_flight != 0 || reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int w, h, kind, len, pick, bin;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    in_flight = 0;
    stim_count = 0;
    steady = 1'b0;
    clear_hist();
    img_w = 1;
    img_h = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty read, flag edges, unused mode, clears, channel extremes
    queue_item(MODE_READ, 0, 0, 0, 0);
    queue_item(MODE_ACCUM, 1, 1, 1, 0);
    queue_item(MODE_ACCUM, 0, 1, 4, 0);
    queue_item(MODE_READ, 0, 0, 0, 1);
    queue_item(MODE_SPARE, 255, 255, 255, 255);
    queue_item(MODE_READ, 0, 0, 0, 4);
    queue_item(MODE_ACCUM, 2, 2, 3, 0);
    queue_item(MODE_READ, 0, 0, 0, 2);
    queue_item(MODE_CLEAR, 0, 0, 0, 0);
    queue_item(MODE_READ, 0, 0, 0, 1);
    queue_item(MODE_ACCUM, 255, 255, 255, 0);
    queue_item(MODE_ACCUM, 253, 253, 253, 0);
    queue_item(MODE_ACCUM, 255, 254, 250, 0);
    queue_item(MODE_READ, 0, 0, 0, 255);
    queue_item(MODE_READ, 0, 0, 0, 253);
    queue_item(MODE_ACCUM, 254, 255, 255, 0);
    queue_item(MODE_READ, 0, 0, 0, 254);
    queue_item(MODE_CLEAR, 255, 255, 255, 255);
    queue_item(MODE_ACCUM, 0, 0, 0, 0);
    queue_item(MODE_READ, 0, 0, 0, 0);
    queue_item(MODE_ACCUM, 0, 255, 128, 0);
    queue_item(MODE_READ, 255, 255, 255, 128);
    stim_count = 0;

    while (stim_count < 1950) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0: begin w = 1; h = 1; end
        1: begin w = 4095; h = 4095; end
        2: begin w = 0; h = $urandom_range(0, 4095); end
        3: begin w = $urandom_range(0, 4095); h = 0; end
        4: begin w = 4095; h = 1; end
        7: begin w = $urandom_range(1, 4095); h = $urandom_range(1, 60); end
        default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 12); end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
      end else begin
        write_reg(REG_HEIGHT, h);
        write_reg(REG_WIDTH, w);
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 3)), $urandom_range(0, 4095));

      steady = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 25) kind = 0;
      else if (pick < 45) kind = 1;
      else if (pick < 55) kind = 2;
      else if (pick < 80) kind = 3;
      else kind = 4;
      foreach (pal[i, j]) pal[i][j] = $urandom_range(0, 255);
      if ($urandom_range(0, 9) < 7) queue_item(MODE_CLEAR, 0, 0, 0, 0);

      len = $urandom_range(10, 60);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          queue_item(MODE_SPARE, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255));
        end else if (pick < 4) begin
          queue_item(MODE_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255));
        end else if (pick < 22) begin
          if (seen.size() > 0 && $urandom_range(0, 9) < 6)
            bin = seen[$urandom_range(0, seen.size() - 1)];
          else
            bin = $urandom_range(0, 255);
          queue_item(MODE_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), bin);
        end else begin
          add_pixel(kind);
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/rhc_pkg.sv
sv/rgb_histogram_classifier.sv
sv/rhc_checker.sv
tb/tb_rgb_histogram_classifier.sv
